/* sv/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths and parameter defaults for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

   localparam int unsigned ADDR_W         = 14;
   localparam int unsigned FRAME_OUT_W    = 2;
   localparam int unsigned PAGE_OUT_W     = 11;
   localparam int unsigned FAULT_W        = 16;
   localparam int unsigned FRAMES_DEF     = 4;
   localparam int unsigned PAGE_WORDS_DEF = 10;

endpackage

/* sv/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative page frame set with exact least recently used ranks.
//
//   Channel   Direction   Ports                       Moves
//   req       in          req_valid/req_ready         one word address
//   rsp       out         rsp_valid/rsp_ready         hit, frame, eviction, fault total
//
// An access passes through the accepting state, the divide state in which
// the divider multiplies by the reciprocal of the page size, then the frame
// scan over the filled frames, which stops at the first hit and is
// skipped while no frame is filled, then the update state.
// Synchronous active high reset empties all frames and clears the fault count.
// A result waits in its output register while the next transfer is accepted;
// the update cycle stalls only if the previous result has not been taken.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int unsigned FRAMES     = lpr_pkg::FRAMES_DEF,
   parameter int unsigned PAGE_WORDS = lpr_pkg::PAGE_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lpr_pkg::ADDR_W-1:0]      req_access_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [lpr_pkg::FRAME_OUT_W-1:0] rsp_frame_used,
   output logic                            rsp_evicted,
   output logic [lpr_pkg::PAGE_OUT_W-1:0]  rsp_evicted_page,
   output logic [lpr_pkg::FAULT_W-1:0]     rsp_fault_total
);
   import lpr_pkg::*;

   localparam int unsigned PAGE_W = $clog2(((2 ** ADDR_W) - 1) / PAGE_WORDS + 1);
   localparam int unsigned FIDX_W = $clog2(FRAMES);
   localparam int unsigned FILL_W = $clog2(FRAMES + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAMES);
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   state_type         state_ff;
   logic [PAGE_W-1:0] resident_page_ff [FRAMES];
   logic [FIDX_W-1:0] rank_ff [FRAMES];
   logic [FIDX_W-1:0] rank_in [FRAMES];
   logic [FILL_W-1:0] frames_filled_ff;
   logic [FAULT_W-1:0] fault_ff;
   logic [FAULT_W-1:0] fault_in;

   logic [PAGE_W-1:0] page_ff;
   logic [FIDX_W-1:0] scan_idx_ff;
   logic              hit_ff;
   logic [FIDX_W-1:0] hit_idx_ff;
   logic [FIDX_W-1:0] hit_rank_ff;
   logic [FIDX_W-1:0] vic_idx_ff;
   logic [FIDX_W-1:0] vic_rank_ff;
   logic [PAGE_W-1:0] vic_page_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff;
   logic                   rsp_evicted_ff;
   logic [PAGE_OUT_W-1:0]  rsp_page_ff;
   logic [FAULT_W-1:0]     rsp_fault_ff;

   logic              div_start;
   logic              div_done;
   logic [ADDR_W-1:0] div_quotient;

   logic [PAGE_W-1:0] cur_page;
   logic [FIDX_W-1:0] cur_rank;
   logic              scan_last;
   logic              frames_full;
   logic              commit;
   logic              evict;
   logic              age_all;
   logic [FIDX_W-1:0] upd_frame;
   logic [FIDX_W-1:0] old_rank;
   logic              page_we;
   logic [FIDX_W+FRAME_OUT_W-1:0] frame_ext;
   logic [PAGE_W+PAGE_OUT_W-1:0]  page_ext;
   logic [FRAMES-1:0] mru_vec;

   assign req_ready = (state_ff == ST_IDLE);
   assign div_start = req_valid && req_ready;

   lpr_divider #(
      .DIVISOR (PAGE_WORDS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_access_address),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign cur_page    = resident_page_ff[scan_idx_ff];
   assign cur_rank    = rank_ff[scan_idx_ff];
   assign scan_last   = ((FILL_W'(scan_idx_ff) + FILL_W'(1)) == frames_filled_ff);
   assign frames_full = (frames_filled_ff == FILL_FULL);
   assign commit      = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign evict       = !hit_ff && frames_full;
   assign age_all     = !hit_ff && !frames_full;
   assign page_we     = commit && !hit_ff;

   always_comb begin
      if (hit_ff) begin
         upd_frame = hit_idx_ff;
         old_rank  = hit_rank_ff;
      end else if (frames_full) begin
         upd_frame = vic_idx_ff;
         old_rank  = vic_rank_ff;
      end else begin
         upd_frame = frames_filled_ff[FIDX_W-1:0];
         old_rank  = '0;
      end
   end

   always_comb begin
      for (int k = 0; k < FRAMES; k++) begin
         rank_in[k] = rank_ff[k];
         if ((FILL_W'(k) < frames_filled_ff) && (FIDX_W'(k) != upd_frame) &&
             (age_all || (rank_ff[k] < old_rank))) begin
            rank_in[k] = rank_ff[k] + FIDX_W'(1);
         end
      end
      rank_in[upd_frame] = '0;
   end

   assign fault_in  = (hit_ff || (fault_ff == FAULT_MAX)) ? fault_ff : fault_ff + FAULT_W'(1);
   assign frame_ext = {{FRAME_OUT_W{1'b0}}, upd_frame};
   assign page_ext  = {{PAGE_OUT_W{1'b0}}, vic_page_ff};

   always_ff @(posedge clock) begin
      if (page_we) begin
         resident_page_ff[upd_frame] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         frames_filled_ff <= '0;
         fault_ff         <= '0;
         for (int k = 0; k < FRAMES; k++) begin
            rank_ff[k] <= '0;
         end
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (div_start) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  page_ff     <= div_quotient[PAGE_W-1:0];
                  hit_ff      <= 1'b0;
                  scan_idx_ff <= '0;
                  state_ff    <= (frames_filled_ff == '0) ? ST_UPDATE : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if ((scan_idx_ff == '0) || (cur_rank > vic_rank_ff)) begin
                  vic_idx_ff  <= scan_idx_ff;
                  vic_rank_ff <= cur_rank;
                  vic_page_ff <= cur_page;
               end
               if (cur_page == page_ff) begin
                  hit_ff      <= 1'b1;
                  hit_idx_ff  <= scan_idx_ff;
                  hit_rank_ff <= cur_rank;
                  state_ff    <= ST_UPDATE;
               end else if (scan_last) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  scan_idx_ff <= scan_idx_ff + FIDX_W'(1);
               end
            end
            ST_UPDATE: begin
               if (commit) begin
                  rank_ff          <= rank_in;
                  fault_ff         <= fault_in;
                  if (age_all) begin
                     frames_filled_ff <= frames_filled_ff + FILL_W'(1);
                  end
                  rsp_hit_ff       <= hit_ff;
                  rsp_frame_ff     <= frame_ext[FRAME_OUT_W-1:0];
                  rsp_evicted_ff   <= evict;
                  rsp_page_ff      <= evict ? page_ext[PAGE_OUT_W-1:0] : '0;
                  rsp_fault_ff     <= fault_in;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_used   = rsp_frame_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_page_ff;
   assign rsp_fault_total  = rsp_fault_ff;

   always_comb begin
      for (int k = 0; k < FRAMES; k++) begin
         mru_vec[k] = (FILL_W'(k) < frames_filled_ff) && (rank_ff[k] == '0);
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      frames_filled_ff <= FILL_FULL)
      else $error("frame fill count exceeds the number of frames");

   a_one_mru: assert property (@(posedge clock) disable iff (reset)
      (frames_filled_ff != '0) |-> $onehot(mru_vec))
      else $error("filled frames do not hold exactly one most recent rank");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block ready again right after an input transfer");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (!rsp_hit && frames_full))
      else $error("eviction reported on a hit or with an empty frame");

endmodule

/* sv/lpr_divider.sv */
// ----------------------------------------------------------------------------
// LRU page replacement divider
// Divides by a constant through multiplication by a scaled reciprocal; the
// quotient is registered and valid in the cycle after start.
// ----------------------------------------------------------------------------
module lpr_divider #(
   parameter int unsigned DIVISOR = lpr_pkg::PAGE_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lpr_pkg::ADDR_W-1:0] dividend,
   output logic                       done,
   output logic [lpr_pkg::ADDR_W-1:0] quotient
);
   import lpr_pkg::*;

   localparam int unsigned SHIFT  = ADDR_W + $clog2(DIVISOR);
   localparam int unsigned PROD_W = SHIFT + ADDR_W;
   localparam logic [PROD_W-1:0] RECIP = PROD_W'(((2 ** SHIFT) + DIVISOR - 1) / DIVISOR);

   logic              done_ff;
   logic [ADDR_W-1:0] quot_ff;
   logic [PROD_W-1:0] product;

   assign product = PROD_W'(dividend) * RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
         if (start) begin
            quot_ff <= product[PROD_W-1:SHIFT];
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
